// ===== sv/mml_pkg.sv =====
// Package for the mecanum mixer with speed limiting and slew limiting.
// Holds the item structs, field widths, register indexes and the sequencer states.
// Depends on nothing; used by mml_div and mecanum_mix_limit_ramp.
package mml_pkg;

  localparam int unsigned NumWheels = 4;
  localparam int unsigned WheelIdxW = $clog2(NumWheels);

  localparam int unsigned SpdW  = 16;           // command and wheel speed width, Q.4
  localparam int unsigned CfgW  = 15;           // speed cap and slew step register width
  localparam int unsigned TgtW  = SpdW + 2;     // mixed target before limiting
  localparam int unsigned MagW  = TgtW - 1;     // magnitude of a mixed target
  localparam int unsigned ProdW = MagW + CfgW;  // magnitude times the speed cap
  localparam int unsigned QuoW  = CfgW;         // scaled magnitude never exceeds the speed cap
  localparam int unsigned CntW  = $clog2(QuoW + 1);

  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgMaxSpeed = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgRampStep = 8'd1;

  localparam logic [CfgW-1:0] MaxSpeedRst = 15'd16000;
  localparam logic [CfgW-1:0] RampStepRst = 15'd32;

  typedef struct packed {
    logic signed [SpdW-1:0] forward_cmd;
    logic signed [SpdW-1:0] lateral_cmd;
    logic signed [SpdW-1:0] rotation_cmd;
  } mml_in_t;

  typedef struct packed {
    logic signed [SpdW-1:0] left_front_out;
    logic signed [SpdW-1:0] right_front_out;
    logic signed [SpdW-1:0] left_back_out;
    logic signed [SpdW-1:0] right_back_out;
    logic                   was_limited;
  } mml_out_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PEAK,
    S_MUL,
    S_DIV,
    S_RAMP,
    S_DONE
  } mml_state_e;

endpackage

// ===== sv/mml_div.sv =====
// Restoring divider used to scale each wheel target under the speed limit.
// One quotient bit per cycle; the quotient is known to fit QuoW bits.
// Depends on mml_pkg.
module mml_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [mml_pkg::ProdW-1:0]  dividend_i,
  input  logic [mml_pkg::MagW-1:0]   divisor_i,
  output logic                       done_o,
  output logic [mml_pkg::QuoW-1:0]   quotient_o
);
  import mml_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [MagW-1:0]   rem_q, rem_d;
  logic [QuoW-1:0]   low_q, low_d;
  logic [QuoW-1:0]   quo_q, quo_d;
  logic [MagW-1:0]   dsr_q, dsr_d;
  logic [MagW:0]     trial;

  // The partial remainder always stays below the divisor, so MagW+1 bits hold the trial.
  assign trial = {rem_q, low_q[QuoW-1]} - {1'b0, dsr_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    low_d  = low_q;
    quo_d  = quo_q;
    dsr_d  = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(QuoW);
      rem_d  = dividend_i[ProdW-1:QuoW];
      low_d  = dividend_i[QuoW-1:0];
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (trial[MagW]) begin
        rem_d = {rem_q[MagW-2:0], low_q[QuoW-1]};
        quo_d = {quo_q[QuoW-2:0], 1'b0};
      end else begin
        rem_d = trial[MagW-1:0];
        quo_d = {quo_q[QuoW-2:0], 1'b1};
      end
      low_d = {low_q[QuoW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    low_q <= low_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

`ifndef SYNTHESIS
  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> (rem_q < dsr_q))
    else $error("divider remainder reached the divisor");

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> ($past(busy_q) && !busy_q))
    else $error("divider finished without a run");

  a_start_when_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q)
    else $error("divider started while busy");
`endif

endmodule

// ===== sv/mecanum_mix_limit_ramp.sv =====
// Top level of the mecanum wheel mixer with proportional speed limiting and slew limiting.
// Holds the sequencer, the wheel state and the output register; instantiates mml_div.
// Depends on mml_pkg and mml_div.

// Each accepted item carries forward, lateral and rotation commands in signed Q.4. They
// are mixed into four wheel targets. If the largest target magnitude exceeds the speed cap
// (register 0), every target is scaled by the cap over that peak, multiplying first and
// truncating the quotient toward zero. Each wheel then moves from its previous output
// towards its target by at most the slew step (register 1), and the new outputs leave as
// one item together with a flag that tells whether limiting took place. The block works on
// one item at a time and drops in_ready_o until its work is finished; the result waits
// in an output register, so the next item can be accepted while it is still pending.
// The commands are mixed at the accepting edge; the peak search then takes one wheel per
// cycle and is followed by the slew step of each wheel. With limiting each wheel also
// passes through the shared restoring divider: it is loaded, produces the quotient bits
// one bit per cycle and hands the quotient back, and then the wheel takes its slew step.
// If the previous result is still waiting in the output register, the block holds its
// finished item until that is taken.
// The configuration port is always ready; registers should only be written while idle.
module mecanum_mix_limit_ramp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  mml_pkg::mml_in_t              in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output mml_pkg::mml_out_t             out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [mml_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [mml_pkg::CfgDataW-1:0]  cfg_data_i
);
  import mml_pkg::*;

  mml_state_e state_q, state_d;

  logic [CfgW-1:0]        speed_cap_q;
  logic [CfgW-1:0]        slew_step_q;
  logic [TgtW-1:0]        tgt_q  [NumWheels];
  logic [SpdW-1:0]        last_q [NumWheels];
  logic [MagW-1:0]        peak_q;
  logic                   limited_q;
  logic [SpdW-1:0]        lim_q;
  logic [WheelIdxW-1:0]   idx_q;
  logic                   out_valid_q;
  mml_out_t               out_q;

  logic                   accept;
  logic                   out_load;
  logic                   div_start;
  logic                   div_done;
  logic [QuoW-1:0]        div_quo;
  logic [MagW-1:0]        cur_mag;
  logic [TgtW-1:0]        cur_tgt;
  logic [ProdW-1:0]       product;
  logic [SpdW-1:0]        ramp_tgt;
  logic [SpdW:0]          diff;
  logic [SpdW:0]          diff_mag;
  logic [SpdW:0]          stepped;
  logic [SpdW-1:0]        next_speed;
  logic                   over_limit;
  logic [TgtW-1:0]        f_ext, r_ext, c_ext;

  assign accept      = in_valid_i && in_ready_o;
  assign in_ready_o  = (state_q == S_IDLE);
  assign cfg_ready_o = 1'b1;

  // Output register is free when empty or being drained in this cycle.
  assign out_load = (state_q == S_DONE) && (!out_valid_q || out_ready_i);

  assign f_ext = {{2{in_data_i.forward_cmd[SpdW-1]}},  in_data_i.forward_cmd};
  assign r_ext = {{2{in_data_i.lateral_cmd[SpdW-1]}},  in_data_i.lateral_cmd};
  assign c_ext = {{2{in_data_i.rotation_cmd[SpdW-1]}}, in_data_i.rotation_cmd};

  assign cur_tgt = tgt_q[idx_q];
  always_comb begin
    if (cur_tgt[TgtW-1]) begin
      cur_mag = MagW'(-cur_tgt);
    end else begin
      cur_mag = cur_tgt[MagW-1:0];
    end
  end

  assign over_limit = (peak_q > {{(MagW-CfgW){1'b0}}, speed_cap_q});
  assign product    = ProdW'(cur_mag) * ProdW'(speed_cap_q);
  assign div_start  = (state_q == S_MUL);

  mml_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (product),
    .divisor_i  (peak_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // Slew step: unlimited targets are known to fit the speed width.
  assign ramp_tgt = limited_q ? lim_q : cur_tgt[SpdW-1:0];
  assign diff     = {ramp_tgt[SpdW-1], ramp_tgt} - {last_q[idx_q][SpdW-1], last_q[idx_q]};
  assign diff_mag = diff[SpdW] ? -diff : diff;

  always_comb begin
    if (diff[SpdW]) begin
      stepped = {last_q[idx_q][SpdW-1], last_q[idx_q]} - {2'b00, slew_step_q};
    end else begin
      stepped = {last_q[idx_q][SpdW-1], last_q[idx_q]} + {2'b00, slew_step_q};
    end
    if (diff_mag > {2'b00, slew_step_q}) begin
      next_speed = stepped[SpdW-1:0];
    end else begin
      next_speed = ramp_tgt;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_PEAK;
        end
      end
      S_PEAK: begin
        if (idx_q == WheelIdxW'(NumWheels - 1)) begin
          state_d = S_RAMP;
          if (peak_q > {{(MagW-CfgW){1'b0}}, speed_cap_q}
              || cur_mag > {{(MagW-CfgW){1'b0}}, speed_cap_q}) begin
            state_d = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_RAMP;
        end
      end
      S_RAMP: begin
        if (idx_q == WheelIdxW'(NumWheels - 1)) begin
          state_d = S_DONE;
        end else if (limited_q) begin
          state_d = S_MUL;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      speed_cap_q <= MaxSpeedRst;
      slew_step_q <= RampStepRst;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CfgMaxSpeed: speed_cap_q <= cfg_data_i[CfgW-1:0];
        CfgRampStep: slew_step_q <= cfg_data_i[CfgW-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer datapath.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q     <= '0;
      limited_q <= 1'b0;
      peak_q    <= '0;
      for (int i = 0; i < NumWheels; i++) begin
        last_q[i] <= '0;
      end
    end else begin
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            idx_q  <= '0;
            peak_q <= '0;
          end
        end
        S_PEAK: begin
          if (cur_mag > peak_q) begin
            peak_q <= cur_mag;
          end
          idx_q <= idx_q + 1'b1;
          if (idx_q == WheelIdxW'(NumWheels - 1)) begin
            limited_q <= over_limit || (cur_mag > {{(MagW-CfgW){1'b0}}, speed_cap_q});
          end
        end
        S_RAMP: begin
          last_q[idx_q] <= next_speed;
          idx_q         <= idx_q + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Mixed targets and the scaled target need no reset.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      tgt_q[0] <= -f_ext - r_ext - c_ext;
      tgt_q[1] <=  f_ext - r_ext - c_ext;
      tgt_q[2] <= -f_ext + r_ext - c_ext;
      tgt_q[3] <=  f_ext + r_ext - c_ext;
    end
    if ((state_q == S_DIV) && div_done) begin
      if (cur_tgt[TgtW-1]) begin
        lim_q <= -{1'b0, div_quo};
      end else begin
        lim_q <= {1'b0, div_quo};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.left_front_out  <= last_q[0];
      out_q.right_front_out <= last_q[1];
      out_q.left_back_out   <= last_q[2];
      out_q.right_back_out  <= last_q[3];
      out_q.was_limited     <= limited_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_accept_starts_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_PEAK) && (peak_q == '0) && (idx_q == '0))
    else $error("accepted item did not start the peak search");

  a_limited_means_over: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_MUL) || (state_q == S_DIV)) |-> limited_q && over_limit)
    else $error("divider used without the limit being exceeded");

  a_quotient_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == S_DIV) && div_done) |-> (div_quo <= speed_cap_q))
    else $error("scaled target exceeds the speed cap");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i && (state_q == S_DONE)) |=> (state_q == S_DONE))
    else $error("result loaded over a pending item");
`endif

endmodule
